// File: hw/rtl/b38_pkg.sv
// Shared types, codes and character tables for the base-38 stream decoder.
package b38_pkg;

   localparam int unsigned B38_MAX_RES   = 3;
   localparam int unsigned B38_RSP_DEPTH = 8;
   localparam int unsigned VALUE_W       = 27;
   localparam int unsigned WEIGHT_W      = 22;

   localparam logic [1:0] ST_BYTE    = 2'd0;
   localparam logic [1:0] ST_BADCHAR = 2'd1;
   localparam logic [1:0] ST_BADLEN  = 2'd2;
   localparam logic [1:0] ST_TOOBIG  = 2'd3;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_UPZ   = 8'h5a;
   localparam logic [7:0] CH_DASH  = 8'h2d;
   localparam logic [7:0] CH_DOT   = 8'h2e;

   localparam logic [5:0] DIG_DASH = 6'd36;
   localparam logic [5:0] DIG_DOT  = 6'd37;
   localparam logic [5:0] DIG_UPA  = 6'd10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] status;
      logic       run_last;
      logic       string_end;
   } rslt_type;

   typedef struct packed {
      logic               discarding;
      logic               bad;
      logic [2:0]         count;
      logic [VALUE_W-1:0] value;
   } grp_type;

   typedef struct packed {
      logic [1:0]                   cnt;
      rslt_type [B38_MAX_RES-1:0]   rslt;
   } step_type;

   // {bad, digit}
   function automatic logic [6:0] b38_digit(input logic [7:0] c);
      logic [6:0] r;
      r = {1'b1, 6'd0};
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b0, 6'(c - CH_ZERO)};
      end else if (c >= CH_UPA && c <= CH_UPZ) begin
         r = {1'b0, 6'(c - CH_UPA) + DIG_UPA};
      end else if (c == CH_DASH) begin
         r = {1'b0, DIG_DASH};
      end else if (c == CH_DOT) begin
         r = {1'b0, DIG_DOT};
      end
      return r;
   endfunction

   function automatic logic [WEIGHT_W-1:0] b38_weight(input logic [2:0] pos);
      logic [WEIGHT_W-1:0] w;
      case (pos)
         3'd0:    w = 22'd1;
         3'd1:    w = 22'd38;
         3'd2:    w = 22'd1444;
         3'd3:    w = 22'd54872;
         default: w = 22'd2085136;
      endcase
      return w;
   endfunction

endpackage

// File: hw/rtl/b38_req_if.sv
// Character channel: one encoded character per beat.
interface b38_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// File: hw/rtl/b38_rsp_if.sv
// Result channel: one decoded byte or status per beat.
interface b38_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [1:0] status;
   logic       run_last;
   logic       string_end;

   modport source (output valid, output data_byte, output status, output run_last,
                   output string_end, input ready);
   modport sink   (input valid, input data_byte, input status, input run_last,
                   input string_end, output ready);
endinterface

// File: hw/rtl/base38_stream_decoder_core.sv
// Base-38 stream decoder: character input register, group logic and result queue.
//
// req_chan carries one ASCII character per beat with last_char on the final
// character of a string. rsp_chan carries one result per beat: a decoded byte
// (status 0) or a single error status, with run_last on the last result of a
// character and string_end on the last result of the string.
// Characters are taken at one per cycle while req_chan.ready is high. Each
// accepted character is held in an input register, then decoded into up to
// three results that are written at once into a RSP_DEPTH-entry result queue;
// the earliest result of a character is valid on rsp_chan once it has passed
// through the input register and been written into the result queue.
// req_chan.ready stays high while the queue has room for the character in the
// input register and one more, so a string decodes at one character per cycle
// as long as the receiver takes a result in most cycles; the queue drains one
// result per cycle while rsp_chan.ready is high.
// When the receiver stalls, results pile up in the queue and req_chan.ready
// drops once the free entries no longer cover three results for the character
// in the input register plus three for one more character.
// Synchronous reset empties the queue and the input register and clears the
// group state and error drop mode.
module base38_stream_decoder_core
   import b38_pkg::*;
#(
   parameter int unsigned RSP_DEPTH = B38_RSP_DEPTH
)(
   input logic      clock,
   input logic      reset,
   b38_req_if.sink  req_chan,
   b38_rsp_if.source rsp_chan
);

   localparam int unsigned PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned CNT_W = $clog2(RSP_DEPTH + 1);

   logic                 stg_vld_ff, stg_vld_in;
   logic [7:0]           stg_char_ff;
   logic                 stg_last_ff;
   grp_type              grp_ff, grp_in;
   grp_type              grp_step;
   step_type             step;
   rslt_type             fifo_ff [RSP_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]           push_cnt;
   logic                 pop;
   logic                 req_take;
   logic [CNT_W:0]       need;

   b38_step u_step (
      .grp       (grp_ff),
      .char_code (stg_char_ff),
      .last_char (stg_last_ff),
      .grp_next  (grp_step),
      .step      (step)
   );

   assign need = (CNT_W + 1)'(cnt_ff) + (stg_vld_ff ? (CNT_W + 1)'(B38_MAX_RES) : '0);
   assign req_chan.ready = (need <= (CNT_W + 1)'(RSP_DEPTH - B38_MAX_RES));
   assign req_take = req_chan.valid & req_chan.ready;

   assign push_cnt = stg_vld_ff ? step.cnt : 2'd0;
   assign pop      = rsp_chan.valid & rsp_chan.ready;

   assign stg_vld_in = req_take;
   assign grp_in     = stg_vld_ff ? grp_step : grp_ff;
   assign wr_ptr_in  = wr_ptr_ff + PTR_W'(push_cnt);
   assign rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in     = cnt_ff + CNT_W'(push_cnt) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_vld_ff <= 1'b0;
         grp_ff     <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
      end else begin
         stg_vld_ff <= stg_vld_in;
         grp_ff     <= grp_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stg_char_ff <= req_chan.char_code;
         stg_last_ff <= req_chan.last_char;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < B38_MAX_RES; k++) begin
         if (2'(k) < push_cnt) begin
            fifo_ff[wr_ptr_ff + PTR_W'(k)] <= step.rslt[k];
         end
      end
   end

   assign rsp_chan.valid      = (cnt_ff != '0);
   assign rsp_chan.data_byte  = fifo_ff[rd_ptr_ff].data_byte;
   assign rsp_chan.status     = fifo_ff[rd_ptr_ff].status;
   assign rsp_chan.run_last   = fifo_ff[rd_ptr_ff].run_last;
   assign rsp_chan.string_end = fifo_ff[rd_ptr_ff].string_end;

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      (CNT_W + 1)'(cnt_ff) + (CNT_W + 1)'(push_cnt) <= (CNT_W + 1)'(RSP_DEPTH))
      else $error("result queue overflow");

   a_group_bound : assert property (@(posedge clock) disable iff (reset)
      grp_ff.count <= 3'd4)
      else $error("group holds more than four characters");

   a_clear_at_end : assert property (@(posedge clock) disable iff (reset)
      stg_vld_ff && stg_last_ff |=> grp_ff == '0)
      else $error("group state not cleared after string end");

   a_end_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.string_end |-> rsp_chan.run_last)
      else $error("string end on a result that is not the last of its beat");

endmodule

// File: hw/rtl/b38_step.sv
// Per-character group update and result generation for the base-38 decoder.
module b38_step
   import b38_pkg::*;
(
   input  grp_type    grp,
   input  logic [7:0] char_code,
   input  logic       last_char,
   output grp_type    grp_next,
   output step_type   step
);

   logic [5:0]          dgt;
   logic                dgt_bad;
   logic [2:0]          pos;
   logic [2:0]          pos_next;
   logic [VALUE_W:0]    prod;
   logic [VALUE_W-1:0]  val_next;
   logic                bad_next;
   logic [1:0]          nbytes;
   logic                emit;
   logic                toobig;
   logic [1:0]          st;
   logic                err;

   assign {dgt_bad, dgt} = b38_digit(char_code);
   assign pos      = (grp.count > 3'd4) ? 3'd4 : grp.count;
   assign pos_next = pos + 3'd1;
   assign prod     = (VALUE_W + 1)'(dgt) * (VALUE_W + 1)'(b38_weight(pos));
   assign val_next = dgt_bad ? grp.value : grp.value + prod[VALUE_W-1:0];
   assign bad_next = grp.bad | dgt_bad;

   always_comb begin
      nbytes = 2'd0;
      emit   = 1'b0;
      if (pos_next == 3'd5) begin
         nbytes = 2'd3;
         emit   = 1'b1;
      end else if (last_char) begin
         emit = 1'b1;
         if (pos_next == 3'd4) begin
            nbytes = 2'd2;
         end else if (pos_next == 3'd2) begin
            nbytes = 2'd1;
         end
      end
   end

   always_comb begin
      case (nbytes)
         2'd3:    toobig = |val_next[VALUE_W-1:24];
         2'd2:    toobig = |val_next[VALUE_W-1:16];
         2'd1:    toobig = |val_next[VALUE_W-1:8];
         default: toobig = 1'b0;
      endcase
   end

   always_comb begin
      if (nbytes == 2'd0) begin
         st = ST_BADLEN;
      end else if (bad_next) begin
         st = ST_BADCHAR;
      end else if (toobig) begin
         st = ST_TOOBIG;
      end else begin
         st = ST_BYTE;
      end
   end

   assign err = (st != ST_BYTE);

   always_comb begin
      step     = '0;
      grp_next = grp;
      if (grp.discarding) begin
         if (last_char) begin
            grp_next = '0;
         end
      end else if (!emit) begin
         grp_next.value = val_next;
         grp_next.count = pos_next;
         grp_next.bad   = bad_next;
      end else begin
         grp_next            = '0;
         grp_next.discarding = err & ~last_char;
         if (err) begin
            step.cnt                = 2'd1;
            step.rslt[0].status     = st;
            step.rslt[0].run_last   = 1'b1;
            step.rslt[0].string_end = 1'b1;
         end else begin
            step.cnt = nbytes;
            for (int k = 0; k < B38_MAX_RES; k++) begin
               if (2'(k) < nbytes) begin
                  step.rslt[k].data_byte = val_next[8*k +: 8];
                  step.rslt[k].status    = ST_BYTE;
               end
            end
            step.rslt[2'(nbytes - 2'd1)].run_last   = 1'b1;
            step.rslt[2'(nbytes - 2'd1)].string_end = last_char;
         end
      end
   end

endmodule
